### src/apig_pkg.sv
// Shared types, widths and codes of the array partition interval generator.
`timescale 1ns / 1ps

package apig_pkg;

    localparam int DIV_STAGES = 32;

    typedef logic [30:0] u31_t;

    typedef enum logic [1:0] {
        KIND_BLOCK_SIZE   = 2'd0,
        KIND_BLOCK_COUNT  = 2'd1,
        KIND_STRIDE       = 2'd2,
        KIND_BLOCK_STRIDE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t kind;
        u31_t  range_min;
        u31_t  dim_length;
        u31_t  part_id;
        u31_t  block_size;
        u31_t  part_request;
    } in_t;

    typedef struct packed {
        u31_t               parts_count;
        u31_t               part_min;
        logic signed [31:0] part_max;
        u31_t               part_length;
        u31_t               seq_begin;
        u31_t               seq_length;
        u31_t               seq_period;
        u31_t               seq_count;
        logic               last;
        logic               error;
    } out_t;

    // Everything a request carries down the pipeline; later fields fill in as it goes.
    typedef struct packed {
        kind_t       kind;
        logic        err;
        u31_t        rmin;
        u31_t        len;
        u31_t        id;
        u31_t        size;
        u31_t        req;
        u31_t        parts;
        logic [31:0] q1;
        u31_t        r1;
        logic [61:0] prod_a;
        u31_t        slen;
        logic [31:0] q2;
        u31_t        r2;
        logic [31:0] q3;
        u31_t        r3;
        u31_t        prod_b;
    } ctx_t;

endpackage

### src/apig_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying the request context.
`timescale 1ns / 1ps

module apig_div import apig_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        ctx_in,
    input  logic [31:0] dividend,
    input  u31_t        divisor,
    output logic        out_valid,
    output ctx_t        ctx_out,
    output logic [31:0] quotient,
    output u31_t        remainder
);

    logic        vld_reg [DIV_STAGES];
    ctx_t        ctx_reg [DIV_STAGES];
    u31_t        rem_reg [DIV_STAGES];
    logic [31:0] quo_reg [DIV_STAGES];
    logic [31:0] dvd_reg [DIV_STAGES];
    u31_t        dvs_reg [DIV_STAGES];

    u31_t        r_in      [DIV_STAGES];
    logic [31:0] q_in      [DIV_STAGES];
    logic [31:0] d_in      [DIV_STAGES];
    u31_t        v_in      [DIV_STAGES];
    logic [31:0] trial     [DIV_STAGES];
    logic [31:0] diff      [DIV_STAGES];
    u31_t        rem_next  [DIV_STAGES];
    logic [31:0] quo_next  [DIV_STAGES];
    logic [31:0] dvd_next  [DIV_STAGES];

    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                r_in[i] = '0;
                q_in[i] = '0;
                d_in[i] = dividend;
                v_in[i] = divisor;
            end else begin
                r_in[i] = rem_reg[i-1];
                q_in[i] = quo_reg[i-1];
                d_in[i] = dvd_reg[i-1];
                v_in[i] = dvs_reg[i-1];
            end
        end
    end

    // The partial remainder stays below the divisor, so the shifted trial fits in 32 bits.
    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            trial[i]    = {r_in[i], d_in[i][31]};
            diff[i]     = trial[i] - {1'b0, v_in[i]};
            dvd_next[i] = {d_in[i][30:0], 1'b0};
            if (trial[i] >= {1'b0, v_in[i]}) begin
                rem_next[i] = diff[i][30:0];
                quo_next[i] = {q_in[i][30:0], 1'b1};
            end else begin
                rem_next[i] = trial[i][30:0];
                quo_next[i] = {q_in[i][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                ctx_reg[i] <= (i == 0) ? ctx_in : ctx_reg[(i == 0) ? 0 : i - 1];
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                dvd_reg[i] <= dvd_next[i];
                dvs_reg[i] <= v_in[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign ctx_out   = ctx_reg[DIV_STAGES-1];
    assign quotient  = quo_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];

endmodule

### src/array_partition_interval_generator_top.sv
// Top level of the array partition interval generator: request pipeline and result output.
//
// A request enters on s_valid/s_ready with s_data and leaves as one or two results on
// m_valid/m_ready with m_data; the last result of a request carries last = 1.
// Block-cyclic requests with a partial last block for the asked part give a second,
// spill result. A zero block size (block-size and block-stride kinds) or a zero part
// request (block-count kind) gives a single result with error = 1. From acceptance
// to the first result a request passes an input register, three 32-stage dividers in
// a row, two multiply stages, one assembly stage and the output register. A request
// giving one result does not hold the pipeline; one giving two results holds it while
// the spill result goes out. The pipeline moves only when the output register is free
// or being emptied, so s_ready falls while a result waits or a spill result is pending.
// When the receiver stalls, the whole pipeline holds; nothing is lost or repeated.
// Synchronous reset clears all valid bits.
`timescale 1ns / 1ps

module array_partition_interval_generator_top import apig_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic signed [63:0] MAX31_S = 64'sd2147483647;

    function automatic u31_t sat31(input logic signed [63:0] v);
        u31_t r;
        if (v < 64'sd0) begin
            r = '0;
        end else if (v > MAX31_S) begin
            r = MAX31_S[30:0];
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_max(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v < -64'sd1) begin
            r = -32'sd1;
        end else if (v > MAX31_S) begin
            r = MAX31_S[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic adv;
    logic m_valid_reg, spill_valid_reg;
    out_t m_data_reg, spill_data_reg;

    assign adv     = !spill_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input register.
    logic s0_vld_reg;
    ctx_t s0_ctx_reg;
    ctx_t s0_ctx_next;
    u31_t req_len_min;

    always_comb begin
        req_len_min = (s_data.part_request < s_data.dim_length) ? s_data.part_request
                                                                 : s_data.dim_length;
        s0_ctx_next       = '0;
        s0_ctx_next.kind  = s_data.kind;
        s0_ctx_next.rmin  = s_data.range_min;
        s0_ctx_next.len   = s_data.dim_length;
        s0_ctx_next.id    = s_data.part_id;
        s0_ctx_next.size  = s_data.block_size;
        s0_ctx_next.req   = s_data.part_request;
        s0_ctx_next.parts = (req_len_min == '0) ? 31'd1 : req_len_min;
        s0_ctx_next.err   = ((s_data.kind == KIND_BLOCK_SIZE ||
                              s_data.kind == KIND_BLOCK_STRIDE) && s_data.block_size == '0) ||
                            (s_data.kind == KIND_BLOCK_COUNT && s_data.part_request == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_ctx_reg <= s0_ctx_next;
        end
    end

    // First division: parts for block size, block size for block count, entries for stride,
    // whole blocks for block stride.
    logic [31:0] div1_dvd;
    u31_t        div1_dvs;

    always_comb begin
        unique case (s0_ctx_reg.kind)
            KIND_BLOCK_SIZE: begin
                div1_dvd = {1'b0, s0_ctx_reg.len} + {1'b0, s0_ctx_reg.size} - 32'd1;
                div1_dvs = s0_ctx_reg.size;
            end
            KIND_BLOCK_COUNT: begin
                div1_dvd = {1'b0, s0_ctx_reg.len};
                div1_dvs = s0_ctx_reg.req;
            end
            KIND_STRIDE: begin
                div1_dvd = {1'b0, s0_ctx_reg.len};
                div1_dvs = s0_ctx_reg.parts;
            end
            default: begin
                div1_dvd = {1'b0, s0_ctx_reg.len};
                div1_dvs = s0_ctx_reg.size;
            end
        endcase
    end

    logic        d1_vld;
    ctx_t        d1_ctx;
    logic [31:0] d1_q;
    u31_t        d1_r;

    apig_div u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s0_vld_reg),
        .ctx_in    (s0_ctx_reg),
        .dividend  (div1_dvd),
        .divisor   (div1_dvs),
        .out_valid (d1_vld),
        .ctx_out   (d1_ctx),
        .quotient  (d1_q),
        .remainder (d1_r)
    );

    // Multiply stage: part offset and block-cyclic period.
    logic ma_vld_reg;
    ctx_t ma_ctx_reg;
    ctx_t ma_ctx_next;
    u31_t parts3;
    u31_t mul_x;
    logic [61:0] slen_full;

    always_comb begin
        if (d1_q < {1'b0, d1_ctx.req}) begin
            parts3 = (d1_q == 32'd0) ? 31'd1 : d1_q[30:0];
        end else begin
            parts3 = (d1_ctx.req == '0) ? 31'd1 : d1_ctx.req;
        end
        mul_x = (d1_ctx.kind == KIND_BLOCK_COUNT) ? d1_q[30:0] : d1_ctx.size;
        // For block-stride requests the period never exceeds the larger of length and block size, so 31 bits hold it.
        slen_full = d1_ctx.size * parts3;
        ma_ctx_next        = d1_ctx;
        ma_ctx_next.q1     = d1_q;
        ma_ctx_next.r1     = d1_r;
        ma_ctx_next.prod_a = d1_ctx.id * mul_x;
        ma_ctx_next.slen   = slen_full[30:0];
        if (d1_ctx.kind == KIND_BLOCK_SIZE) begin
            ma_ctx_next.parts = d1_q[30:0];
        end else if (d1_ctx.kind == KIND_BLOCK_STRIDE) begin
            ma_ctx_next.parts = parts3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ma_vld_reg <= 1'b0;
        end else if (adv) begin
            ma_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ma_ctx_reg <= ma_ctx_next;
        end
    end

    // Second division: full rounds of the block-cyclic period.
    logic        d2_vld;
    ctx_t        d2_ctx;
    logic [31:0] d2_q;
    u31_t        d2_r;

    apig_div u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (ma_vld_reg),
        .ctx_in    (ma_ctx_reg),
        .dividend  ({1'b0, ma_ctx_reg.len}),
        .divisor   (ma_ctx_reg.slen),
        .out_valid (d2_vld),
        .ctx_out   (d2_ctx),
        .quotient  (d2_q),
        .remainder (d2_r)
    );

    ctx_t d3_in_ctx;

    always_comb begin
        d3_in_ctx    = d2_ctx;
        d3_in_ctx.q2 = d2_q;
        d3_in_ctx.r2 = d2_r;
    end

    // Third division: whole blocks and spill within the last partial round.
    logic        d3_vld;
    ctx_t        d3_ctx;
    logic [31:0] d3_q;
    u31_t        d3_r;

    apig_div u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d2_vld),
        .ctx_in    (d3_in_ctx),
        .dividend  ({1'b0, d2_r}),
        .divisor   (d2_ctx.size),
        .out_valid (d3_vld),
        .ctx_out   (d3_ctx),
        .quotient  (d3_q),
        .remainder (d3_r)
    );

    // Multiply stage: entries from full rounds.
    logic        mb_vld_reg;
    ctx_t        mb_ctx_reg;
    ctx_t        mb_ctx_next;
    logic [61:0] prod_b_full;

    always_comb begin
        prod_b_full        = d3_ctx.q2[30:0] * d3_ctx.size;
        mb_ctx_next        = d3_ctx;
        mb_ctx_next.q3     = d3_q;
        mb_ctx_next.r3     = d3_r;
        mb_ctx_next.prod_b = prod_b_full[30:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mb_vld_reg <= 1'b0;
        end else if (adv) begin
            mb_vld_reg <= d3_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mb_ctx_reg <= mb_ctx_next;
        end
    end

    // Assembly stage: begin, part length and sequence fields per kind.
    typedef struct packed {
        logic               err;
        logic               zero_base;
        logic               has_spill;
        u31_t               parts;
        logic signed [63:0] begin_idx;
        logic [31:0]        plen;
        u31_t               seq_len;
        u31_t               seq_period;
        logic [31:0]        seq_count;
        logic [31:0]        spill_begin;
        u31_t               spill;
    } asm_t;

    logic               f1_vld_reg;
    asm_t               f1_reg;
    asm_t               f1_next;
    logic signed [63:0] off_begin;
    logic signed [63:0] tail;
    logic signed [63:0] tail_c;
    logic               id_not_last;
    logic               blk_gt;
    logic               blk_eq;
    logic [31:0]        ent3;
    logic [31:0]        ent2;

    always_comb begin
        off_begin   = $signed({33'b0, mb_ctx_reg.rmin}) + $signed({2'b0, mb_ctx_reg.prod_a});
        tail        = $signed({33'b0, mb_ctx_reg.len}) - $signed({2'b0, mb_ctx_reg.prod_a});
        tail_c      = (tail < 64'sd0) ? 64'sd0 : tail;
        id_not_last = ({1'b0, mb_ctx_reg.id} + 32'd1) < {1'b0, mb_ctx_reg.req};
        blk_gt      = mb_ctx_reg.q3 > {1'b0, mb_ctx_reg.id};
        blk_eq      = mb_ctx_reg.q3 == {1'b0, mb_ctx_reg.id};
        ent2        = {1'b0, mb_ctx_reg.q1[30:0]} +
                      {31'b0, (mb_ctx_reg.r1 > mb_ctx_reg.id)};
        if (blk_gt) begin
            ent3 = {1'b0, mb_ctx_reg.prod_b} + {1'b0, mb_ctx_reg.size};
        end else if (blk_eq) begin
            ent3 = {1'b0, mb_ctx_reg.prod_b} + {1'b0, mb_ctx_reg.r3};
        end else begin
            ent3 = {1'b0, mb_ctx_reg.prod_b};
        end

        f1_next             = '0;
        f1_next.err         = mb_ctx_reg.err;
        f1_next.parts       = mb_ctx_reg.parts;
        f1_next.spill       = mb_ctx_reg.r3;
        // The spill block follows the whole blocks, so it ends at the end of the dimension.
        f1_next.spill_begin = {1'b0, mb_ctx_reg.rmin} + {1'b0, mb_ctx_reg.len} -
                              {1'b0, mb_ctx_reg.r3};
        unique case (mb_ctx_reg.kind)
            KIND_BLOCK_SIZE: begin
                f1_next.begin_idx  = off_begin;
                f1_next.plen       = (tail_c > $signed({33'b0, mb_ctx_reg.size}))
                                     ? {1'b0, mb_ctx_reg.size} : tail_c[31:0];
                f1_next.seq_len    = f1_next.plen[30:0];
                f1_next.seq_period = f1_next.plen[30:0];
                f1_next.seq_count  = 32'd1;
            end
            KIND_BLOCK_COUNT: begin
                f1_next.begin_idx  = off_begin;
                f1_next.plen       = id_not_last ? {1'b0, mb_ctx_reg.q1[30:0]}
                                                 : tail_c[31:0];
                f1_next.seq_len    = f1_next.plen[30:0];
                f1_next.seq_period = f1_next.plen[30:0];
                f1_next.seq_count  = 32'd1;
            end
            KIND_STRIDE: begin
                f1_next.zero_base  = 1'b1;
                f1_next.begin_idx  = $signed({33'b0, mb_ctx_reg.rmin}) +
                                     $signed({33'b0, mb_ctx_reg.id});
                f1_next.plen       = ent2;
                f1_next.seq_len    = 31'd1;
                f1_next.seq_period = mb_ctx_reg.parts;
                f1_next.seq_count  = ent2;
            end
            default: begin
                f1_next.zero_base  = 1'b1;
                f1_next.has_spill  = blk_eq && (mb_ctx_reg.r3 != '0);
                f1_next.begin_idx  = off_begin;
                f1_next.plen       = ent3;
                f1_next.seq_len    = mb_ctx_reg.size;
                f1_next.seq_period = mb_ctx_reg.slen;
                f1_next.seq_count  = mb_ctx_reg.q2 + {31'b0, blk_gt};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (adv) begin
            f1_vld_reg <= mb_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg <= f1_next;
        end
    end

    // Result formatting with saturation.
    logic signed [63:0] pmin64;
    logic signed [63:0] plen64;
    out_t               res0;
    out_t               res1;
    logic               two_res;

    always_comb begin
        pmin64  = f1_reg.zero_base ? 64'sd0 : f1_reg.begin_idx;
        plen64  = $signed({32'b0, f1_reg.plen});
        two_res = f1_reg.has_spill && !f1_reg.err;

        res0             = '0;
        res0.parts_count = f1_reg.parts;
        res0.part_min    = sat31(pmin64);
        res0.part_max    = sat_max(pmin64 + plen64 - 64'sd1);
        res0.part_length = sat31(plen64);
        res0.seq_begin   = sat31(f1_reg.begin_idx);
        res0.seq_length  = f1_reg.seq_len;
        res0.seq_period  = f1_reg.seq_period;
        res0.seq_count   = sat31($signed({32'b0, f1_reg.seq_count}));
        res0.last        = !f1_reg.has_spill;

        res1            = res0;
        res1.seq_begin  = sat31($signed({32'b0, f1_reg.spill_begin}));
        res1.seq_length = f1_reg.spill;
        res1.seq_period = f1_reg.spill;
        res1.seq_count  = 31'd1;
        res1.last       = 1'b1;

        if (f1_reg.err) begin
            res0       = '0;
            res0.last  = 1'b1;
            res0.error = 1'b1;
        end
    end

    // Output register and spill register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            spill_valid_reg <= 1'b0;
        end else if (m_valid_reg && m_ready && spill_valid_reg) begin
            spill_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= f1_vld_reg;
            if (f1_vld_reg) begin
                spill_valid_reg <= two_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && spill_valid_reg) begin
            m_data_reg <= spill_data_reg;
        end else if (adv && f1_vld_reg) begin
            m_data_reg     <= res0;
            spill_data_reg <= res1;
        end
    end

endmodule
